>>> src/lnfw_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lnfw_pkg
// shared types, constants, microcode program and power-of-ten tables for the
// character lcd numeric field writer
// ---------------------------------------------------------------------------
package lnfw_pkg;

    localparam int MAX_DIGITS  = 5;
    localparam int CNT_W       = 3;
    localparam int PC_W        = 3;
    localparam int MAG_W       = 17;
    localparam int POW_W       = 14;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W      = MAG_W + RECIP_W;

    localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;
    localparam logic [7:0] LINE_TWO_OFFSET = 8'h40;
    localparam logic [7:0] ASCII_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_MINUS      = 8'h2D;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;

    typedef struct packed {
        logic [15:0] value;
        logic [2:0]  width;
        logic        with_sign;
        logic        second_line;
        logic [5:0]  column;
    } t_in_word;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } t_out_word;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_ADDR,
        OP_SIGN,
        OP_MUL,
        OP_QUOT,
        OP_DIGIT
    } t_op;

    typedef enum logic [2:0] {
        J_NEXT,
        J_ALWAYS,
        J_NO_SIGN,
        J_NO_DIGITS,
        J_MORE_DIGITS
    } t_jmp;

    typedef struct packed {
        t_op              op;
        logic             emit;
        t_jmp             jmp;
        logic [PC_W-1:0]  target;
    } t_ctrl;

    typedef struct packed {
        logic with_sign;
        logic no_digits;
        logic last_digit;
        logic emit_ready;
    } t_stat;

    // microcode program
    function automatic t_ctrl f_ucode(input logic [PC_W-1:0] pc);
        t_ctrl c;
        c = '{op: OP_NOP, emit: 1'b0, jmp: J_ALWAYS, target: PC_W'(0)};
        case (pc)
            PC_W'(0): c = '{op: OP_LOAD,  emit: 1'b0, jmp: J_NEXT,        target: PC_W'(0)};
            PC_W'(1): c = '{op: OP_ADDR,  emit: 1'b1, jmp: J_NO_SIGN,     target: PC_W'(3)};
            PC_W'(2): c = '{op: OP_SIGN,  emit: 1'b1, jmp: J_NEXT,        target: PC_W'(0)};
            PC_W'(3): c = '{op: OP_NOP,   emit: 1'b0, jmp: J_NO_DIGITS,   target: PC_W'(0)};
            PC_W'(4): c = '{op: OP_MUL,   emit: 1'b0, jmp: J_NEXT,        target: PC_W'(0)};
            PC_W'(5): c = '{op: OP_QUOT,  emit: 1'b0, jmp: J_NEXT,        target: PC_W'(0)};
            PC_W'(6): c = '{op: OP_DIGIT, emit: 1'b1, jmp: J_MORE_DIGITS, target: PC_W'(4)};
            default:  c = '{op: OP_NOP,   emit: 1'b0, jmp: J_ALWAYS,      target: PC_W'(0)};
        endcase
        return c;
    endfunction

    // place value of the digit with l positions left
    function automatic logic [POW_W-1:0] f_pow10(input logic [CNT_W-1:0] l);
        logic [POW_W-1:0] p;
        case (l)
            CNT_W'(1): p = POW_W'(1);
            CNT_W'(2): p = POW_W'(10);
            CNT_W'(3): p = POW_W'(100);
            CNT_W'(4): p = POW_W'(1000);
            CNT_W'(5): p = POW_W'(10000);
            default:   p = POW_W'(1);
        endcase
        return p;
    endfunction

    // floor(2^RECIP_SHIFT / place value)
    function automatic logic [RECIP_W-1:0] f_recip(input logic [CNT_W-1:0] l);
        logic [RECIP_W-1:0] r;
        case (l)
            CNT_W'(1): r = RECIP_W'(16777216);
            CNT_W'(2): r = RECIP_W'(1677721);
            CNT_W'(3): r = RECIP_W'(167772);
            CNT_W'(4): r = RECIP_W'(16777);
            CNT_W'(5): r = RECIP_W'(1677);
            default:   r = RECIP_W'(16777216);
        endcase
        return r;
    endfunction

endpackage

>>> src/lnfw_sequencer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lnfw_sequencer
// step counter over the microcode program with conditional jumps
// ---------------------------------------------------------------------------
module lnfw_sequencer
    import lnfw_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  t_stat  i_stat,
    output t_ctrl  o_ctrl,
    output logic   o_fire
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctrl           ctrl;
    logic            fire;
    logic            take;

    always_comb begin
        ctrl = f_ucode(r_pc);
        if (ctrl.op == OP_LOAD) begin
            fire = i_in_valid;
        end else if (ctrl.emit) begin
            fire = i_stat.emit_ready;
        end else begin
            fire = 1'b1;
        end
        case (ctrl.jmp)
            J_NEXT:        take = 1'b0;
            J_ALWAYS:      take = 1'b1;
            J_NO_SIGN:     take = ~i_stat.with_sign;
            J_NO_DIGITS:   take = i_stat.no_digits;
            J_MORE_DIGITS: take = ~i_stat.last_digit;
            default:       take = 1'b1;
        endcase
        if (!fire) begin
            n_pc = r_pc;
        end else if (take) begin
            n_pc = ctrl.target;
        end else begin
            n_pc = r_pc + PC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = ctrl;
    assign o_fire = fire;

endmodule

>>> src/lnfw_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lnfw_datapath
// field registers, reciprocal digit divider and output word register
// ---------------------------------------------------------------------------
module lnfw_datapath
    import lnfw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctrl     i_ctrl,
    input  logic      i_fire,
    input  t_in_word  i_in_word,
    input  logic      i_out_stall,
    output t_stat     o_stat,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    logic [MAG_W-1:0]  r_mag;
    logic              r_neg;
    logic              r_vneg;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_ws;
    logic              r_line;
    logic [5:0]        r_col;
    logic [PROD_W-1:0] r_prod;
    logic [MAG_W-1:0]  r_q;
    logic [MAG_W-1:0]  r_rem;
    logic              r_out_valid;
    t_out_word         r_out;

    logic [MAG_W-1:0]   in_v17;
    logic               in_neg;
    logic [POW_W-1:0]   pow;
    logic [MAG_W-1:0]   q_est;
    logic [MAG_W-1:0]   q_fix;
    logic [MAG_W-1:0]   rem_fix;
    logic               fix;
    logic               emit_ready;
    t_out_word          word;

    always_comb begin
        in_v17  = {i_in_word.value[15], i_in_word.value};
        in_neg  = i_in_word.value[15];
        pow     = f_pow10(r_cnt);
        q_est   = r_prod[RECIP_SHIFT +: MAG_W];
        fix     = r_rem >= MAG_W'(pow);
        q_fix   = fix ? r_q + MAG_W'(1) : r_q;
        rem_fix = fix ? r_rem - MAG_W'(pow) : r_rem;
        emit_ready = ~r_out_valid | ~i_out_stall;
        word.is_data  = 1'b1;
        word.bus_byte = '0;
        word.last     = 1'b0;
        case (i_ctrl.op)
            OP_ADDR: begin
                word.is_data  = 1'b0;
                word.bus_byte = CMD_SET_DDRAM + {2'b00, r_col}
                              + (r_line ? LINE_TWO_OFFSET : 8'h00);
                word.last     = ~r_ws & (r_cnt == '0);
            end
            OP_SIGN: begin
                word.bus_byte = r_vneg ? CHAR_MINUS : CHAR_SPACE;
                word.last     = r_cnt == '0;
            end
            OP_DIGIT: begin
                word.bus_byte = r_neg ? ASCII_ZERO - q_fix[7:0] : ASCII_ZERO + q_fix[7:0];
                word.last     = r_cnt == CNT_W'(1);
            end
            default: begin
                word.bus_byte = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            case (i_ctrl.op)
                OP_LOAD: begin
                    r_mag  <= in_neg ? MAG_W'(0) - in_v17 : in_v17;
                    r_neg  <= in_neg & ~i_in_word.with_sign;
                    r_vneg <= in_neg;
                    r_cnt  <= (i_in_word.width > CNT_W'(MAX_DIGITS)) ?
                              CNT_W'(MAX_DIGITS) : i_in_word.width;
                    r_ws   <= i_in_word.with_sign;
                    r_line <= i_in_word.second_line;
                    r_col  <= i_in_word.column;
                end
                OP_MUL: begin
                    r_prod <= PROD_W'(r_mag) * PROD_W'(f_recip(r_cnt));
                end
                OP_QUOT: begin
                    r_q   <= q_est;
                    r_rem <= r_mag - MAG_W'(q_est * pow);
                end
                OP_DIGIT: begin
                    r_mag <= rem_fix;
                    r_cnt <= r_cnt - CNT_W'(1);
                end
                default: begin
                    r_q <= r_q;
                end
            endcase
        end
        if (i_fire && i_ctrl.emit) begin
            r_out <= word;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_fire && i_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.with_sign  = r_ws;
    assign o_stat.no_digits  = r_cnt == '0;
    assign o_stat.last_digit = r_cnt == CNT_W'(1);
    assign o_stat.emit_ready = emit_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out;

endmodule

>>> src/lcd_numeric_field_writer_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcd_numeric_field_writer_core
// formats a signed 16-bit number into a set-address command and fixed-width
// sign and digit characters for a character lcd bus
//
//   channel  direction  handshake                word
//   in       input      i_in_valid / o_in_stall  t_in_word: value, width, flags, column
//   out      output     o_out_valid / i_out_stall t_out_word: is_data, bus_byte, last
//
// a field runs a load step, an address step, a sign step for the sign column
// and a digit check; each digit adds a multiply, quotient and digit step, and a
// field with digits adds one closing step, as set by the microcode program on
// the shared reciprocal multiplier and remainder unit
// one field is worked on at a time; the input is stalled until the program
// returns to its load step
// the output register holds a word while i_out_stall is high, and the
// program waits on an emit step until it can be written
// synchronous active-low reset clears the step counter and output valid
// ---------------------------------------------------------------------------
module lcd_numeric_field_writer_core
    import lnfw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_ctrl ctrl;
    t_stat stat;
    logic  fire;

    lnfw_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_fire     (fire)
    );

    lnfw_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_fire      (fire),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    assign o_in_stall = ctrl.op != OP_LOAD;

endmodule

>>> bench/lnfw_field_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lnfw_field_checker
// watches both channels of the numeric field writer, works out the bus
// words that each accepted field must produce and compares them in order
// ---------------------------------------------------------------------------
module lnfw_field_checker
    import lnfw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    output int        o_fail_cnt,
    output int        o_pending,
    output int        o_fields_seen,
    output int        o_bytes_seen
);

    t_out_word field_bytes_q[$];
    int n_fail   = 0;
    int n_fields = 0;
    int n_bytes  = 0;
    int n_wait   = 0;

    assign o_fail_cnt    = n_fail;
    assign o_pending     = n_wait;
    assign o_fields_seen = n_fields;
    assign o_bytes_seen  = n_bytes;

    function automatic void predict_field(input t_in_word w);
        int        mag;
        int        digits;
        int        place;
        int        quo;
        int        l;
        int        i;
        t_out_word o;
        mag    = int'($signed(w.value));
        digits = (int'(w.width) > MAX_DIGITS) ? MAX_DIGITS : int'(w.width);

        o.is_data  = 1'b0;
        o.bus_byte = CMD_SET_DDRAM + {2'b00, w.column}
                     + (w.second_line ? LINE_TWO_OFFSET : 8'h00);
        o.last     = !w.with_sign && (digits == 0);
        field_bytes_q.push_back(o);

        if (w.with_sign) begin
            o.is_data = 1'b1;
            if (mag < 0) begin
                o.bus_byte = CHAR_MINUS;
                mag = -mag;
            end else begin
                o.bus_byte = CHAR_SPACE;
            end
            o.last = (digits == 0);
            field_bytes_q.push_back(o);
        end

        for (l = digits; l > 0; l--) begin
            place = 1;
            for (i = 1; i < l; i++) begin
                place = place * 10;
            end
            quo = mag / place;
            mag = mag - quo * place;
            o.is_data  = 1'b1;
            o.bus_byte = 8'(int'(ASCII_ZERO) + quo);
            o.last     = (l == 1);
            field_bytes_q.push_back(o);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_word exp_w;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                n_bytes++;
                if (field_bytes_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got %0b/%02h/%0b",
                             $time, i_out_word.is_data, i_out_word.bus_byte,
                             i_out_word.last);
                    n_fail++;
                end else begin
                    exp_w = field_bytes_q.pop_front();
                    if (exp_w.is_data !== i_out_word.is_data
                            || exp_w.bus_byte !== i_out_word.bus_byte
                            || exp_w.last !== i_out_word.last) begin
                        $display("%0t: mismatch, expected %0b/%02h/%0b, got %0b/%02h/%0b",
                                 $time, exp_w.is_data, exp_w.bus_byte, exp_w.last,
                                 i_out_word.is_data, i_out_word.bus_byte,
                                 i_out_word.last);
                        n_fail++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_field(i_in_word);
                n_fields++;
            end
            n_wait = field_bytes_q.size();
        end
    end

endmodule

>>> bench/tb_lcd_numeric_field_writer_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lcd_numeric_field_writer_core
// drives numeric fields into the lcd field writer, directed corners first
// and then random fields in bursts, while the output side stalls on its own
// pattern with a long hold-off now and then; the checker beside the block
// predicts and compares every bus word
// ---------------------------------------------------------------------------
module tb_lcd_numeric_field_writer_core;
    import lnfw_pkg::*;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    int fail_cnt;
    int pending;
    int fields_seen;
    int bytes_seen;

    lcd_numeric_field_writer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    lnfw_field_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_word     (i_in_word),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_word    (o_out_word),
        .o_fail_cnt    (fail_cnt),
        .o_pending     (pending),
        .o_fields_seen (fields_seen),
        .o_bytes_seen  (bytes_seen)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_in_word make_field(input int value, input int width,
                                            input bit sign, input bit line2,
                                            input int column);
        t_in_word w;
        w.value       = 16'(value);
        w.width       = 3'(width);
        w.with_sign   = sign;
        w.second_line = line2;
        w.column      = 6'(column);
        return w;
    endfunction

    function automatic t_in_word random_field();
        t_in_word w;
        int       width;
        width = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 5);
        case ($urandom_range(0, 3))
            0: w.value = 16'($urandom);
            1: w.value = 16'($urandom_range(0, 1998) - 999);
            2: w.value = 16'($urandom_range(0, 99));
            default: w.value = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        endcase
        w.width       = 3'(width);
        w.with_sign   = 1'($urandom);
        w.second_line = 1'($urandom);
        w.column      = 6'($urandom);
        return w;
    endfunction

    // called at a rising edge, returns at the edge where the word is taken
    task automatic send_field(input t_in_word w);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
    endtask

    // output side: free, random or patterned stalls, with a long hold-off
    initial begin : out_side
        int         cyc;
        int         hold_left;
        logic [15:0] pat;
        cyc       = 0;
        hold_left = 0;
        pat       = 16'b0110_0001_1100_0100;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 1500 == 700) begin
                hold_left = 200;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                case ((cyc / 400) % 3)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 2) == 0);
                    default: i_out_stall <= pat[cyc % 16];
                endcase
            end
        end
    end

    initial begin : limit
        #2_000_000;
        $display("FAIL lcd_numeric_field_writer_core");
        $finish;
    end

    initial begin : in_side
        t_in_word corner_q[$];
        int       n;
        int       burst;
        int       gap;

        corner_q.push_back(make_field(0,      0, 0, 0, 0));
        corner_q.push_back(make_field(-5,     0, 1, 0, 63));
        corner_q.push_back(make_field(32767,  5, 1, 1, 63));
        corner_q.push_back(make_field(-32768, 5, 1, 0, 0));
        corner_q.push_back(make_field(-32768, 5, 0, 1, 10));
        corner_q.push_back(make_field(12345,  2, 0, 0, 5));
        corner_q.push_back(make_field(1005,   4, 0, 1, 1));
        corner_q.push_back(make_field(-123,   3, 0, 0, 7));
        corner_q.push_back(make_field(7,      7, 1, 1, 20));
        corner_q.push_back(make_field(-1,     6, 1, 0, 33));
        corner_q.push_back(make_field(0,      5, 1, 1, 0));
        corner_q.push_back(make_field(1,      1, 0, 0, 42));
        corner_q.push_back(make_field(-32768, 1, 1, 1, 63));
        corner_q.push_back(make_field(32767,  1, 0, 0, 0));
        corner_q.push_back(make_field(-9,     2, 1, 1, 15));
        corner_q.push_back(make_field(500,    3, 1, 0, 31));
        corner_q.push_back(make_field(-32767, 5, 1, 1, 62));
        corner_q.push_back(make_field(21845,  5, 0, 0, 21));
        corner_q.push_back(make_field(-21846, 5, 1, 1, 42));
        corner_q.push_back(make_field(42,     4, 0, 1, 32));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_q[k]) begin
            send_field(corner_q[k]);
        end

        n = 0;
        while (n < 140) begin
            burst = $urandom_range(1, 12);
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (burst) begin
                send_field(random_field());
                n++;
            end
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;

        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("covered %0d fields and %0d bus words: corner fields, random bursts,",
                 fields_seen, bytes_seen);
        $display("output stalls and a long output hold-off that backs up the input");
        if (fail_cnt == 0) begin
            $display("PASS lcd_numeric_field_writer_core");
        end else begin
            $display("FAIL lcd_numeric_field_writer_core");
        end
        $finish;
    end

endmodule
